// ===== design/sha1md_pkg.sv =====
// ============================================================================
// sha1md_pkg
// shared constants, state encodings and control structs of the sha-1 core
// ============================================================================
package sha1md_pkg;

    localparam logic [31:0] H_INIT_0 = 32'h67452301;
    localparam logic [31:0] H_INIT_1 = 32'hEFCDAB89;
    localparam logic [31:0] H_INIT_2 = 32'h98BADCFE;
    localparam logic [31:0] H_INIT_3 = 32'h10325476;
    localparam logic [31:0] H_INIT_4 = 32'hC3D2E1F0;

    localparam logic [31:0] K_RND_0 = 32'h5A827999;
    localparam logic [31:0] K_RND_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_RND_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_RND_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] POS_LEN       = 6'd56;   // 448 bits into the block
    localparam logic [5:0] POS_LAST      = 6'd63;

    localparam logic [6:0] RND_FIRST     = 7'd0;
    localparam logic [6:0] RND_PHASE_1   = 7'd20;
    localparam logic [6:0] RND_PHASE_2   = 7'd40;
    localparam logic [6:0] RND_PHASE_3   = 7'd60;
    localparam logic [6:0] RND_LAST      = 7'd79;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_COMP,
        S_ADD,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN
    } t_pad;

    typedef enum logic [1:0] {
        SRC_IN,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } t_src;

    typedef enum logic [1:0] {
        FN_CH,
        FN_PAR1,
        FN_MAJ,
        FN_PAR2
    } t_fn;

    typedef struct packed {
        logic push;
        t_src src;
        logic len_add;
        logic round;
        logic first;
        t_fn  fn;
        logic add;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [5:0] pos;
        logic       out_free;
    } t_sts;

endpackage

// ===== design/sha1md_ctrl.sv =====
// ============================================================================
// sha1md_ctrl
// sequencer: byte intake, padding, round count and digest hand-off
// ============================================================================
module sha1md_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_has_byte,
    input  logic              i_last_item,
    output logic              o_ready,
    input  sha1md_pkg::t_sts  i_sts,
    output sha1md_pkg::t_cmd  o_cmd
);
    import sha1md_pkg::*;

    t_state     r_state, n_state;
    t_pad       r_pad, n_pad;
    logic       r_fin, n_fin;
    logic [6:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pad   <= PAD_MARK;
            r_fin   <= 1'b0;
            r_cnt   <= RND_FIRST;
        end else begin
            r_state <= n_state;
            r_pad   <= n_pad;
            r_fin   <= n_fin;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pad   = r_pad;
        n_fin   = r_fin;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_fin = i_last_item;
                    n_pad = PAD_MARK;
                    if (i_has_byte && i_sts.pos == POS_LAST) begin
                        n_state = S_COMP;
                    end else if (i_last_item) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                unique case (r_pad)
                    PAD_MARK: begin
                        n_pad = PAD_ZERO;
                        if (i_sts.pos == POS_LAST) begin
                            n_state = S_COMP;
                        end
                    end
                    PAD_ZERO: begin
                        if (i_sts.pos == POS_LEN) begin
                            n_pad = PAD_LEN;
                        end else if (i_sts.pos == POS_LAST) begin
                            n_state = S_COMP;
                        end
                    end
                    PAD_LEN: begin
                        if (i_sts.pos == POS_LAST) begin
                            n_state = S_COMP;
                        end
                    end
                    default: n_pad = PAD_MARK;
                endcase
            end
            S_COMP: begin
                if (r_cnt == RND_LAST) begin
                    n_cnt   = RND_FIRST;
                    n_state = S_ADD;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_ADD: begin
                if (r_fin && r_pad == PAD_LEN) begin
                    n_state = S_EMIT;
                end else if (r_fin) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                    n_fin   = 1'b0;
                    n_pad   = PAD_MARK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.push    = i_valid && i_has_byte;
                o_cmd.len_add = i_valid && i_has_byte;
                o_cmd.src     = SRC_IN;
            end
            S_PAD: begin
                unique case (r_pad)
                    PAD_MARK: begin
                        o_cmd.push = 1'b1;
                        o_cmd.src  = SRC_MARK;
                    end
                    PAD_ZERO: begin
                        o_cmd.push = (i_sts.pos != POS_LEN);
                        o_cmd.src  = SRC_ZERO;
                    end
                    PAD_LEN: begin
                        o_cmd.push = 1'b1;
                        o_cmd.src  = SRC_LEN;
                    end
                    default: o_cmd.push = 1'b0;
                endcase
            end
            S_COMP: begin
                o_cmd.round = 1'b1;
                o_cmd.first = (r_cnt == RND_FIRST);
                if (r_cnt < RND_PHASE_1) begin
                    o_cmd.fn = FN_CH;
                end else if (r_cnt < RND_PHASE_2) begin
                    o_cmd.fn = FN_PAR1;
                end else if (r_cnt < RND_PHASE_3) begin
                    o_cmd.fn = FN_MAJ;
                end else begin
                    o_cmd.fn = FN_PAR2;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== design/sha1md_dp.sv =====
// ============================================================================
// sha1md_dp
// block buffer and message schedule, round unit, chaining value, output reg
// ============================================================================
module sha1md_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_data_byte,
    input  sha1md_pkg::t_cmd  i_cmd,
    output sha1md_pkg::t_sts  o_sts,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [159:0]      o_out_data
);
    import sha1md_pkg::*;

    logic [511:0] r_blk;
    logic [5:0]   r_pos;
    logic [63:0]  r_len;
    logic [31:0]  r_chain [0:4];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [159:0] r_out;
    logic         r_out_valid;

    logic [63:0]  len_sh;
    logic [7:0]   push_byte;
    logic [31:0]  w0, w2, w8, w13, w_new;
    logic [31:0]  a, b, c, d, e, f, k, t;
    logic         out_free;

    assign len_sh = r_len >> {3'(3'd7 - r_pos[2:0]), 3'b000};

    always_comb begin
        case (i_cmd.src)
            SRC_IN:   push_byte = i_data_byte;
            SRC_MARK: push_byte = PAD_MARK_BYTE;
            SRC_ZERO: push_byte = 8'h00;
            SRC_LEN:  push_byte = len_sh[7:0];
            default:  push_byte = 8'h00;
        endcase
    end

    // word j of the window sits at r_blk[511-32*j -: 32]
    assign w0    = r_blk[511:480];
    assign w2    = r_blk[447:416];
    assign w8    = r_blk[255:224];
    assign w13   = r_blk[95:64];
    assign w_new = {(w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0]),
                    (w13[31] ^ w8[31] ^ w2[31] ^ w0[31])};

    always_comb begin
        if (i_cmd.first) begin
            a = r_chain[0];
            b = r_chain[1];
            c = r_chain[2];
            d = r_chain[3];
            e = r_chain[4];
        end else begin
            a = r_a;
            b = r_b;
            c = r_c;
            d = r_d;
            e = r_e;
        end
        case (i_cmd.fn)
            FN_CH: begin
                f = (b & c) | (~b & d);
                k = K_RND_0;
            end
            FN_PAR1: begin
                f = b ^ c ^ d;
                k = K_RND_1;
            end
            FN_MAJ: begin
                f = (b & c) | (b & d) | (c & d);
                k = K_RND_2;
            end
            default: begin
                f = b ^ c ^ d;
                k = K_RND_3;
            end
        endcase
        t = {a[26:0], a[31:27]} + f + e + k + w0;
    end

    assign out_free = !r_out_valid || i_out_ready;

    // block buffer, schedule window and working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_blk <= {r_blk[503:0], push_byte};
        end else if (i_cmd.round) begin
            r_blk <= {r_blk[479:0], w_new};
        end
        if (i_cmd.round) begin
            r_a <= t;
            r_b <= a;
            r_c <= {b[1:0], b[31:2]};
            r_d <= c;
            r_e <= d;
        end
        if (i_cmd.emit) begin
            r_out <= {r_chain[4], r_chain[3], r_chain[2], r_chain[1], r_chain[0]};
        end
    end

    // message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 6'd0;
            r_len       <= 64'd0;
            r_chain[0]  <= H_INIT_0;
            r_chain[1]  <= H_INIT_1;
            r_chain[2]  <= H_INIT_2;
            r_chain[3]  <= H_INIT_3;
            r_chain[4]  <= H_INIT_4;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_pos <= r_pos + 6'd1;
            end
            if (i_cmd.emit) begin
                r_len <= 64'd0;
            end else if (i_cmd.len_add) begin
                r_len <= r_len + 64'd8;
            end
            if (i_cmd.emit) begin
                r_chain[0] <= H_INIT_0;
                r_chain[1] <= H_INIT_1;
                r_chain[2] <= H_INIT_2;
                r_chain[3] <= H_INIT_3;
                r_chain[4] <= H_INIT_4;
            end else if (i_cmd.add) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
                r_chain[4] <= r_chain[4] + r_e;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.pos      = r_pos;
    assign o_sts.out_free = out_free;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

// ===== design/sha1_message_digest_core.sv =====
// ============================================================================
// sha1_message_digest_core
// sha-1 digest of a byte stream, at most one byte per item, digest on the last item
// ============================================================================
//  channel   dir  payload                                     end of run
//  s_*       in   tdata: data_byte; tuser: has_byte           tlast: last_item
//  m_*       out  tdata: digest_word_0 .. digest_word_4       -
//
//  byte items are taken one per cycle while s_tready is high; every 64th byte
//  starts a compression (80 rounds of the single round unit plus the chaining add)
//  the last item adds the padding bytes (mark, zeros, bit length) and up to two blocks
//  the digest waits in an output register while the next message streams in
//  s_tready stays low while padding or compressing, and while a digest is
//  ready to load but the output register is still full
//  reset is synchronous, active low, and starts a new message
// ============================================================================
module sha1_message_digest_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] has_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata    // [31:0] digest_word_0 .. [159:128] digest_word_4
);
    import sha1md_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sha1md_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .i_has_byte  (s_tuser),
        .i_last_item (s_tlast),
        .o_ready     (s_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sha1md_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (s_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_tready),
        .o_out_valid (m_tvalid),
        .o_out_data  (m_tdata)
    );

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("digest loaded into a full output register");

    a_emit_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (sts.pos == 6'd0))
        else $error("digest emitted with a partial block");

    a_push_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.push && cmd.round))
        else $error("byte push during a compression round");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken right after the last item");
`endif

endmodule
